// ===== src/ovn_pkg.sv =====
// ---------------------------------------------------------------------------
// ovn_pkg: shared types and constants for the octave value noise unit
// Grid geometry, state encoding and controller/datapath command structs.
// ---------------------------------------------------------------------------
package ovn_pkg;

  localparam int SideLog = 4;
  localparam int Side    = 1 << SideLog;
  localparam int AddrW   = 2 * SideLog;
  localparam int OctW    = 3;
  localparam int BiasW   = 13;
  localparam int SampW   = 16;

  localparam logic [0:0] CfgOctaves = 1'b0;
  localparam logic [0:0] CfgBias    = 1'b1;

  typedef enum logic [0:0] {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD00,
    S_RD10,
    S_RD01,
    S_RD11,
    S_TOP,
    S_BOT,
    S_COL,
    S_TERM,
    S_SCALE,
    S_NDIV,
    S_DIV,
    S_OUT
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       load;       // latch query coordinates, clear accumulators
    logic       rd_en;      // issue a seed read
    logic [1:0] corner;     // which corner to read
    logic       cap_corner; // capture read data of the previous corner
    logic       do_top;
    logic       do_bot;
    logic       do_col;
    logic       do_term;    // accumulate weighted term, start scale division
    logic       sdiv_step;  // one step of the scale division
    logic       next_oct;   // close the octave
    logic       ndiv_start;
    logic       ndiv_step;
    logic       emit;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic last_oct;
    logic sdiv_done;
    logic ndiv_done;
  } stat_t;

endpackage

// ===== src/ovn_ctrl.sv =====
// ---------------------------------------------------------------------------
// ovn_ctrl: query sequencer
// Walks each octave through four seed reads, the blends, the weighted
// accumulate and the scale division, then runs the normalising division.
// ---------------------------------------------------------------------------
module ovn_ctrl import ovn_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  go_query,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (go_query) begin
          cmd.load   = 1'b1;
          state_next = S_RD00;
        end
      end
      S_RD00: begin
        cmd.rd_en = 1'b1; cmd.corner = 2'd0; state_next = S_RD10;
      end
      S_RD10: begin
        cmd.rd_en = 1'b1; cmd.corner = 2'd1; cmd.cap_corner = 1'b1;
        state_next = S_RD01;
      end
      S_RD01: begin
        cmd.rd_en = 1'b1; cmd.corner = 2'd2; cmd.cap_corner = 1'b1;
        state_next = S_RD11;
      end
      S_RD11: begin
        cmd.rd_en = 1'b1; cmd.corner = 2'd3; cmd.cap_corner = 1'b1;
        state_next = S_TOP;
      end
      S_TOP: begin
        cmd.cap_corner = 1'b1; cmd.do_top = 1'b1; state_next = S_BOT;
      end
      S_BOT:  begin cmd.do_bot = 1'b1; state_next = S_COL; end
      S_COL:  begin cmd.do_col = 1'b1; state_next = S_TERM; end
      S_TERM: begin
        cmd.do_term = 1'b1;
        state_next  = S_SCALE;
      end
      S_SCALE: begin
        cmd.sdiv_step = 1'b1;
        if (stat.sdiv_done) begin
          cmd.next_oct = 1'b1;
          if (stat.last_oct) state_next = S_NDIV;
          else               state_next = S_RD00;
        end
      end
      S_NDIV: begin cmd.ndiv_start = 1'b1; state_next = S_DIV; end
      S_DIV: begin
        cmd.ndiv_step = 1'b1;
        if (stat.ndiv_done) state_next = S_OUT;
      end
      S_OUT: begin cmd.emit = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/ovn_dp.sv =====
// ---------------------------------------------------------------------------
// ovn_dp: noise datapath
// Seed memory, bilinear blend, scale recurrence and a shared restoring divider.
// ---------------------------------------------------------------------------
module ovn_dp import ovn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             wr_en,
  input  logic [SideLog-1:0] wr_x,
  input  logic [SideLog-1:0] wr_y,
  input  logic [SampW-1:0] wr_data,
  input  logic [SideLog-1:0] q_x,
  input  logic [SideLog-1:0] q_y,
  input  logic [OctW-1:0]  octave_count,
  input  logic [BiasW-1:0] bias,
  output stat_t            stat,
  output logic             res_valid,
  output logic [SampW-1:0] res_value
);

  // seed store, one write and one registered read port
  logic [SampW-1:0] mem [Side*Side];
  logic [SampW-1:0] rd_data;
  logic [AddrW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) mem[{wr_y, wr_x}] <= wr_data;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  logic [SideLog-1:0] qx, qy;
  logic [OctW-1:0]    oct, n_oct;
  logic [SampW-1:0]   c00, c10, c01, c11;
  logic [1:0]         cap_idx;
  logic [SampW-1:0]   top, bot, val;
  logic [23:0]        scale;
  logic [31:0]        acc, ssum;

  // octave geometry: pitch = Side >> oct, power of two
  logic [SideLog:0]   pitch;
  logic [SideLog-1:0] mask, x1, y1, x2, y2, offx, offy;
  logic [16:0]        bx, by;
  always_comb begin
    pitch = (SideLog+1)'(Side) >> oct;
    mask  = SideLog'(pitch - 1'b1);
    x1    = qx & ~mask;
    y1    = qy & ~mask;
    x2    = SideLog'(x1 + pitch);
    y2    = SideLog'(y1 + pitch);
    offx  = qx & mask;
    offy  = qy & mask;
    // (off << 16) / pitch, pitch a power of two
    bx = 17'((20'(offx) << 16) >> (SideLog - oct));
    by = 17'((20'(offy) << 16) >> (SideLog - oct));
    unique case (cmd.corner)
      2'd0: rd_addr = {y1, x1};
      2'd1: rd_addr = {y1, x2};
      2'd2: rd_addr = {y2, x1};
      default: rd_addr = {y2, x2};
    endcase
  end

  function automatic logic [SampW-1:0] lerp(input logic [SampW-1:0] a,
                                            input logic [SampW-1:0] b,
                                            input logic [16:0] f);
    logic [33:0] v;
    v = 34'(17'h10000 - f) * 34'(a) + 34'(f) * 34'(b);
    return v[31:16];
  endfunction

  // serial divider shared by the scale recurrence and the normalisation
  logic [47:0] dnum;
  logic [31:0] dden;
  logic [32:0] drem;
  logic [47:0] dquo;
  logic [5:0]  dcnt;
  logic [32:0] trial;
  assign trial = {drem[31:0], dnum[47]} - {1'b0, dden};

  logic [12:0] bias_eff;
  assign bias_eff = (bias == '0) ? 13'd1 : bias;

  logic [39:0] term;
  assign term = 40'(val) * 40'(scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      dcnt      <= '0;
    end else begin
      res_valid <= cmd.emit;
      if (cmd.do_term) begin
        dnum <= {16'd0, scale, 8'd0};
        dden <= 32'(bias_eff);
        drem <= '0;
        dcnt <= 6'd48;
      end else if (cmd.ndiv_start) begin
        dnum <= {acc, 16'd0};
        dden <= ssum;
        drem <= '0;
        dcnt <= 6'd48;
      end else if ((cmd.sdiv_step || cmd.ndiv_step) && dcnt != '0) begin
        if (!trial[32]) begin
          drem <= trial;
          dquo <= {dquo[46:0], 1'b1};
        end else begin
          drem <= {drem[31:0], dnum[47]};
          dquo <= {dquo[46:0], 1'b0};
        end
        dnum <= {dnum[46:0], 1'b0};
        dcnt <= dcnt - 1'b1;
      end
    end
  end

  assign stat.sdiv_done = (dcnt == '0);
  assign stat.ndiv_done = (dcnt == '0);
  assign stat.last_oct  = (oct + 1'b1 >= n_oct) || (oct == OctW'(SideLog));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx    <= q_x;
      qy    <= q_y;
      oct   <= '0;
      n_oct <= (octave_count == '0) ? OctW'(1) : octave_count;
      scale <= 24'h010000;
      acc   <= '0;
      ssum  <= '0;
    end
    if (cmd.cap_corner) begin
      unique case (cap_idx)
        2'd0: c00 <= rd_data;
        2'd1: c10 <= rd_data;
        2'd2: c01 <= rd_data;
        default: c11 <= rd_data;
      endcase
    end
    if (cmd.rd_en && cmd.corner == 2'd0) cap_idx <= 2'd0;
    else if (cmd.cap_corner) cap_idx <= cap_idx + 1'b1;
    if (cmd.do_top) top <= lerp(c00, c10, bx);
    if (cmd.do_bot) bot <= lerp(c01, c11, bx);
    if (cmd.do_col) val <= lerp(top, bot, by);
    if (cmd.do_term) begin
      acc  <= acc + 32'(term[39:16]);
      ssum <= ssum + 32'(scale);
    end
    if (cmd.next_oct) begin
      oct   <= oct + 1'b1;
      scale <= (dquo[47:24] != '0) ? 24'hFFFFFF : dquo[23:0];
    end
    if (cmd.emit) res_value <= (dquo[47:16] != '0) ? 16'hFFFF : dquo[15:0];
  end

endmodule

// ===== src/octave_value_noise_2d_unit.sv =====
// ---------------------------------------------------------------------------
// octave_value_noise_2d_unit: 2D octave value noise over a 16x16 seed grid
// Controller sequences seed reads, blends and serial divisions in ovn_dp.
// ---------------------------------------------------------------------------
// Seed write: busy stays low. Query over n octaves: per octave the seed reads
// and blends, then the serial scale division; after the last octave the
// normalising division runs and the word is presented. A new request is
// taken only while busy is low, so queries do not overlap.
// noise_value is strobed by valid for one cycle and cannot be stalled.
// Reset restores octave_count 3 and bias 2.0; seed memory is not cleared.
module octave_value_noise_2d_unit import ovn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             req_type,
  input  logic [3:0]       cell_x,
  input  logic [3:0]       cell_y,
  input  logic [15:0]      seed_value,
  output logic             valid,
  output logic [15:0]      noise_value,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data
);

  logic [OctW-1:0]  octave_count;
  logic [BiasW-1:0] bias_q8_8;
  cmd_t  cmd;
  stat_t stat;
  logic  accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= OctW'(3);
      bias_q8_8    <= BiasW'(512);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgOctaves: octave_count <= cfg_data[OctW-1:0];
        default:    bias_q8_8    <= cfg_data[BiasW-1:0];
      endcase
    end
  end

  ovn_ctrl u_ctrl (
    .clk, .rst,
    .go_query (accept && req_type == REQ_QUERY),
    .stat, .cmd, .busy
  );

  ovn_dp u_dp (
    .clk, .rst, .cmd,
    .wr_en        (accept && req_type == REQ_WRITE),
    .wr_x         (cell_x),
    .wr_y         (cell_y),
    .wr_data      (seed_value),
    .q_x          (cell_x),
    .q_y          (cell_y),
    .octave_count (octave_count),
    .bias         (bias_q8_8),
    .stat,
    .res_valid    (valid),
    .res_value    (noise_value)
  );

  a_valid_pulse: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid) else $error("result strobe longer than one cycle");
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy)) else $error("result without a query in flight");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type) |=> busy) else $error("query not taken");

endmodule
